### hw/rtl/oahm_pkg.sv
// Shared types, constants and codes for the open-address hash map.
// No dependencies; every other file of the block imports this package.
package oahm_pkg;

  // Default sizes for the top-level parameters.
  localparam int SLOTS_DEF      = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths of the request and response transactions.
  localparam int KEY_W   = 32;
  localparam int HASH_W  = 64;
  localparam int VALUE_W = 32;
  localparam int LIVE_W  = 7;

  // Extra probes allowed beyond one full pass over the table.
  localparam int PROBE_EXTRA = 16;

  // Perturb shift applied after each probe.
  localparam int PERTURB_SHIFT = 5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_APPLY
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   key_hash;
    logic [VALUE_W-1:0]  new_value;
    logic [VALUE_W-1:0]  fallback_value;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [VALUE_W-1:0]  read_value;
    logic                status;
    logic [LIVE_W-1:0]   live_count;
  } rsp_t;

  // Per-slot state: used covers both live keys and tombstones.
  typedef struct packed {
    logic used;
    logic tomb;
  } slot_stat_t;

  // Write enables of the slot store, one per field memory.
  typedef struct packed {
    logic stat;
    logic key;
    logic val;
  } wr_ctl_t;

endpackage

### hw/rtl/open_address_hash_map.sv
// Open-address hash map: SLOTS-entry key/value table with perturbed probing and
// tombstones; one response per request. After reset the slot-state memory is
// swept clear before the first request is taken, and a clear request takes the
// same sweep. Lookup, insert and remove pass an accept state; then, for each
// slot probed, a read of the slot store and a compare that steps the index
// through the probe unit; then a commit state, which waits until the output
// register can take the response. An insert of a
// new key is refused with status 1 once the filled slots, tombstones included,
// reach two thirds of SLOTS. A finished response waits in an output register.
// Depends on oahm_pkg, oahm_step and oahm_store.
module open_address_hash_map
  import oahm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int LIMIT = SLOTS + PROBE_EXTRA;
  localparam int N_W   = $clog2(LIMIT);
  localparam int F_W   = CNT_W + 2;
  localparam logic [F_W-1:0] FILL_LIMIT = F_W'(2 * SLOTS);

  state_t state, state_next;

  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [HASH_W-1:0]     perturb;
  logic [VALUE_BITS-1:0] nv_r;
  logic [VALUE_W-1:0]    fb_r;
  logic [IDX_W-1:0]      idx;
  logic [N_W-1:0]        n;
  logic                  have_free;
  logic [IDX_W-1:0]      free_slot;
  logic                  empty_seen;
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_val;
  logic [IDX_W-1:0]      tgt;
  logic                  pend;
  logic [CNT_W-1:0]      live, live_next;
  logic [CNT_W-1:0]      filled, filled_next;
  rsp_t                  rsp_next;

  logic [IDX_W-1:0]      idx_step;
  logic [HASH_W-1:0]     perturb_step;

  logic                  rd_en;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  slot_stat_t            rd_stat;
  wr_ctl_t               wr_ctl;
  logic [IDX_W-1:0]      wr_addr;
  slot_stat_t            wr_stat;

  logic                  key_hit, at_limit, probe_end, hf_upd, can_out, full;
  logic [IDX_W-1:0]      fs_upd;
  logic [F_W-1:0]        filled3;

  oahm_step #(
    .IDX_W(IDX_W)
  ) u_step (
    .idx          (idx),
    .perturb      (perturb),
    .idx_next     (idx_step),
    .perturb_next (perturb_step)
  );

  oahm_store #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_key  (rd_key),
    .rd_val  (rd_val),
    .rd_stat (rd_stat),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_val  (nv_r),
    .wr_stat (wr_stat)
  );

  // Probe evaluation on the slot just read.
  always_comb begin
    key_hit   = rd_stat.used && !rd_stat.tomb && (rd_key == key_r);
    at_limit  = (n == N_W'(LIMIT - 1));
    probe_end = !rd_stat.used || key_hit || at_limit;
    hf_upd    = have_free || (rd_stat.used && rd_stat.tomb);
    fs_upd    = have_free ? free_slot : idx;
  end

  always_comb begin
    filled3 = F_W'(filled) + F_W'({filled, 1'b0});
    full    = (filled3 >= FILL_LIMIT);
    can_out = !rsp_valid || rsp_ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (idx == IDX_W'(SLOTS - 1)) begin
          state_next = pend ? ST_APPLY : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.op == OP_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = probe_end ? ST_APPLY : ST_READ;
      ST_APPLY: begin
        if (can_out) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs, store controls and the commit of one request.
  always_comb begin
    req_ready   = 1'b0;
    rd_en       = 1'b0;
    wr_ctl      = '0;
    wr_addr     = tgt;
    wr_stat     = '0;
    live_next   = live;
    filled_next = filled;
    rsp_next.found      = hit;
    rsp_next.read_value = fb_r;
    rsp_next.status     = 1'b0;
    case (state)
      ST_CLEAR: begin
        wr_ctl.stat = 1'b1;
        wr_addr     = idx;
      end
      ST_IDLE:  req_ready = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_CHECK: ;
      ST_APPLY: begin
        case (op_r)
          OP_LOOKUP: begin
            if (hit) begin
              rsp_next.read_value = VALUE_W'(hit_val);
            end
          end
          OP_INSERT: begin
            if (hit) begin
              wr_ctl.val = can_out;
            end else if (!(empty_seen || have_free) || full) begin
              rsp_next.status = 1'b1;
            end else begin
              wr_ctl      = '{stat: can_out, key: can_out, val: can_out};
              wr_stat     = '{used: 1'b1, tomb: 1'b0};
              live_next   = live + CNT_W'(1);
              // A reused tombstone was already counted as filled.
              if (!have_free) begin
                filled_next = filled + CNT_W'(1);
              end
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              wr_ctl.stat = can_out;
              wr_stat     = '{used: 1'b1, tomb: 1'b1};
              live_next   = live - CNT_W'(1);
            end
          end
          OP_CLEAR: begin
            rsp_next.found = 1'b0;
            live_next      = '0;
            filled_next    = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp_next.live_count = LIVE_W'(live_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      live      <= '0;
      filled    <= '0;
      have_free <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_APPLY && can_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: idx <= idx + IDX_W'(1);
        ST_IDLE: begin
          if (req_valid) begin
            op_r      <= req.op;
            key_r     <= KEY_BITS'(req.key);
            perturb   <= req.key_hash;
            nv_r      <= VALUE_BITS'(req.new_value);
            fb_r      <= req.fallback_value;
            idx       <= (req.op == OP_CLEAR) ? '0 : req.key_hash[IDX_W-1:0];
            n         <= '0;
            have_free <= 1'b0;
            hit       <= 1'b0;
            pend      <= 1'b1;
          end
        end
        ST_READ: ;
        ST_CHECK: begin
          have_free <= hf_upd;
          free_slot <= fs_upd;
          if (probe_end) begin
            hit        <= key_hit;
            hit_val    <= rd_val;
            empty_seen <= !rd_stat.used;
            tgt        <= (!key_hit && hf_upd) ? fs_upd : idx;
          end else begin
            idx     <= idx_step;
            perturb <= perturb_step;
            n       <= n + N_W'(1);
          end
        end
        ST_APPLY: begin
          if (can_out) begin
            rsp    <= rsp_next;
            live   <= live_next;
            filled <= filled_next;
            pend   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Live entries are a subset of the filled slots.
  a_live_le_filled: assert property (@(posedge clk) disable iff (rst)
    live <= filled)
    else $error("live entry count exceeds filled slot count");

  // The fill limit allows at most one insert past two thirds of the table.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled3 < FILL_LIMIT + F_W'(3))
    else $error("filled slot count passed the fill limit");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a transaction is in flight");

  // A response is only loaded while a request is pending.
  a_apply_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |-> pend)
    else $error("commit without a pending request");
`endif

endmodule

### hw/rtl/oahm_step.sv
// Probe step unit: next slot index i = 5i + perturb + 1 (mod 2**IDX_W) and perturb >> 5.
// Depends on oahm_pkg.
module oahm_step
  import oahm_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic [IDX_W-1:0]  idx,
  input  logic [HASH_W-1:0] perturb,
  output logic [IDX_W-1:0]  idx_next,
  output logic [HASH_W-1:0] perturb_next
);

  // Only the low index bits of perturb survive the mask, so the add is IDX_W wide.
  assign idx_next = IDX_W'({idx, 2'b00}) + idx + perturb[IDX_W-1:0] + IDX_W'(1);
  assign perturb_next = perturb >> PERTURB_SHIFT;

endmodule

### hw/rtl/oahm_store.sv
// Slot store: key, value and slot-state memories with one read and one write port.
// Depends on oahm_pkg.
module oahm_store
  import oahm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [VALUE_BITS-1:0] rd_val,
  output slot_stat_t            rd_stat,
  input  wr_ctl_t               wr_ctl,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [VALUE_BITS-1:0] wr_val,
  input  slot_stat_t            wr_stat
);

  logic [KEY_BITS-1:0]   key_mem  [SLOTS];
  logic [VALUE_BITS-1:0] val_mem  [SLOTS];
  slot_stat_t            stat_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_ctl.key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_ctl.val) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (wr_ctl.stat) begin
      stat_mem[wr_addr] <= wr_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
      rd_stat <= stat_mem[rd_addr];
    end
  end

endmodule
